[design/i2crts_pkg.sv]
// ----------------------------------------------------------------------------
// I2C register transfer sequencer package
// Shared types and constants for the sequencer step logic and its top level.
// ----------------------------------------------------------------------------
package i2crts_pkg;

    localparam logic [1:0] KIND_BEGIN  = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_REP_START = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK = 8'h18;
    localparam logic [7:0] ST_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_SLA_R_ACK = 8'h40;
    localparam logic [7:0] ST_RD_ACK    = 8'h50;
    localparam logic [7:0] ST_RD_NACK   = 8'h58;
    localparam logic [7:0] ST_MASK      = 8'hF8;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START_W = 4'd1,
        PH_SLA_W   = 4'd2,
        PH_REG     = 4'd3,
        PH_NEED    = 4'd4,
        PH_DATA    = 4'd5,
        PH_START_R = 4'd6,
        PH_SLA_R   = 4'd7,
        PH_RD_ACK  = 4'd8,
        PH_RD_NACK = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_SEND  = 3'd2,
        CMD_RACK  = 3'd3,
        CMD_RNACK = 3'd4,
        CMD_STOP  = 3'd5
    } cmd_t;

    typedef struct packed {
        phase_t      phase;
        logic        is_read;
        logic [6:0]  target_address;
        logic [7:0]  reg_byte;
        logic [7:0]  bytes_left;
        logic [7:0]  byte_position;
    } seq_state_t;

    localparam seq_state_t STATE_RESET = '{
        phase:          PH_IDLE,
        is_read:        1'b0,
        target_address: 7'd0,
        reg_byte:       8'd0,
        bytes_left:     8'd0,
        byte_position:  8'd0
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic        direction;
        logic [6:0]  device_address;
        logic [7:0]  register_address;
        logic [7:0]  length;
        logic [7:0]  write_byte;
        logic [7:0]  bus_status;
        logic [7:0]  received_byte;
    } seq_item_t;

    typedef struct packed {
        cmd_t        command;
        logic [7:0]  command_byte;
        logic        want_write_byte;
        logic        read_valid;
        logic [7:0]  read_data;
        logic [7:0]  read_index;
        logic        done_res;
        logic        failed;
    } seq_result_t;

endpackage

[design/i2crts_step.sv]
// ----------------------------------------------------------------------------
// I2C register transfer sequencer step
// Computes the result and the next sequencer state for one input item.
// ----------------------------------------------------------------------------
module i2crts_step
    import i2crts_pkg::*;
(
    input  seq_state_t  state_cur,
    input  seq_item_t   item,
    output seq_state_t  state_next,
    output seq_result_t result
);

    logic [7:0] status;
    logic [7:0] left_dec;
    logic [7:0] pos_inc;

    assign status   = item.bus_status & ST_MASK;
    assign left_dec = state_cur.bytes_left - 8'd1;
    assign pos_inc  = state_cur.byte_position + 8'd1;

    always_comb
    begin
        state_next = state_cur;
        result     = '0;
        result.command = CMD_NONE;
        case (item.kind)
            KIND_BEGIN:
            begin
                if (state_cur.phase == PH_IDLE)
                begin
                    state_next.is_read        = item.direction;
                    state_next.target_address = item.device_address;
                    state_next.reg_byte       = item.register_address;
                    state_next.bytes_left     = (item.direction && item.length == 8'd0) ?
                                                8'd1 : item.length;
                    state_next.byte_position  = 8'd0;
                    state_next.phase          = PH_START_W;
                    result.command            = CMD_START;
                end
            end
            KIND_DATA:
            begin
                if (state_cur.phase == PH_NEED)
                begin
                    result.command           = CMD_SEND;
                    result.command_byte      = item.write_byte;
                    state_next.bytes_left    = left_dec;
                    state_next.byte_position = pos_inc;
                    state_next.phase         = PH_DATA;
                end
            end
            KIND_STATUS:
            begin
                case (state_cur.phase)
                    PH_START_W:
                    begin
                        if (status == ST_START)
                        begin
                            result.command      = CMD_SEND;
                            result.command_byte = {state_cur.target_address, 1'b0};
                            state_next.phase    = PH_SLA_W;
                        end
                        else
                        begin
                            result.done_res  = 1'b1;
                            result.failed    = 1'b1;
                            state_next.phase = PH_IDLE;
                        end
                    end
                    PH_SLA_W:
                    begin
                        if (status == ST_SLA_W_ACK)
                        begin
                            result.command      = CMD_SEND;
                            result.command_byte = state_cur.reg_byte;
                            state_next.phase    = PH_REG;
                        end
                        else
                        begin
                            result.command   = CMD_STOP;
                            result.done_res  = 1'b1;
                            result.failed    = 1'b1;
                            state_next.phase = PH_IDLE;
                        end
                    end
                    PH_REG, PH_DATA:
                    begin
                        if (status != ST_DATA_ACK)
                        begin
                            result.command   = CMD_STOP;
                            result.done_res  = 1'b1;
                            result.failed    = 1'b1;
                            state_next.phase = PH_IDLE;
                        end
                        else if (state_cur.phase == PH_REG && state_cur.is_read)
                        begin
                            result.command   = CMD_START;
                            state_next.phase = PH_START_R;
                        end
                        else if (state_cur.bytes_left != 8'd0)
                        begin
                            result.want_write_byte = 1'b1;
                            state_next.phase       = PH_NEED;
                        end
                        else
                        begin
                            result.command   = CMD_STOP;
                            result.done_res  = 1'b1;
                            state_next.phase = PH_IDLE;
                        end
                    end
                    PH_START_R:
                    begin
                        if (status == ST_REP_START)
                        begin
                            result.command      = CMD_SEND;
                            result.command_byte = {state_cur.target_address, 1'b1};
                            state_next.phase    = PH_SLA_R;
                        end
                        else
                        begin
                            result.done_res  = 1'b1;
                            result.failed    = 1'b1;
                            state_next.phase = PH_IDLE;
                        end
                    end
                    PH_SLA_R:
                    begin
                        if (status == ST_SLA_R_ACK)
                        begin
                            if (state_cur.bytes_left > 8'd1)
                            begin
                                result.command   = CMD_RACK;
                                state_next.phase = PH_RD_ACK;
                            end
                            else
                            begin
                                result.command   = CMD_RNACK;
                                state_next.phase = PH_RD_NACK;
                            end
                        end
                        else
                        begin
                            result.command   = CMD_STOP;
                            result.done_res  = 1'b1;
                            result.failed    = 1'b1;
                            state_next.phase = PH_IDLE;
                        end
                    end
                    PH_RD_ACK:
                    begin
                        if (status == ST_RD_ACK)
                        begin
                            result.read_valid        = 1'b1;
                            result.read_data         = item.received_byte;
                            result.read_index        = state_cur.byte_position;
                            state_next.byte_position = pos_inc;
                            state_next.bytes_left    = left_dec;
                            if (left_dec > 8'd1)
                            begin
                                result.command   = CMD_RACK;
                                state_next.phase = PH_RD_ACK;
                            end
                            else
                            begin
                                result.command   = CMD_RNACK;
                                state_next.phase = PH_RD_NACK;
                            end
                        end
                        else
                        begin
                            result.done_res  = 1'b1;
                            result.failed    = 1'b1;
                            state_next.phase = PH_IDLE;
                        end
                    end
                    PH_RD_NACK:
                    begin
                        if (status == ST_RD_NACK)
                        begin
                            result.read_valid        = 1'b1;
                            result.read_data         = item.received_byte;
                            result.read_index        = state_cur.byte_position;
                            state_next.byte_position = pos_inc;
                            state_next.bytes_left    = 8'd0;
                            result.command           = CMD_STOP;
                            result.done_res          = 1'b1;
                            state_next.phase         = PH_IDLE;
                        end
                        else
                        begin
                            result.done_res  = 1'b1;
                            result.failed    = 1'b1;
                            state_next.phase = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = state_cur;
                    end
                endcase
            end
            default:
            begin
                state_next = state_cur;
            end
        endcase
    end

endmodule

[design/i2c_register_transfer_sequencer.sv]
// Each input item is registered in the input register. Its step result is loaded into the
// output register when that register is empty or its result is taken, and is offered there.
// Throughput: one item per cycle while the output is not stalled; the sequencer state is
// updated once per item in the step logic. The input side stalls only while both the input
// and the output register hold an item and the waiting result is not taken.
// Reset (rst_n low, asynchronous) returns the sequencer to idle with all state cleared
// and both pipeline registers empty.
// ----------------------------------------------------------------------------
// I2C register transfer sequencer
// Turns register write and read requests into byte-level bus engine commands.
// ----------------------------------------------------------------------------
module i2c_register_transfer_sequencer
    import i2crts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // direction[0], device_address[7:1], register_address[15:8], length[23:16],
    // write_byte[31:24], bus_status[39:32], received_byte[47:40]
    input  logic [47:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // command[2:0], command_byte[10:3], want_write_byte[11], read_valid[12],
    // read_data[20:13], read_index[28:21], done_res[29], failed[30], zero[31]
    output logic [31:0] m_tdata
);

    seq_state_t  state_reg;
    seq_state_t  state_next;
    seq_item_t   in_item_reg;
    logic        in_valid_reg;
    seq_result_t out_result_reg;
    seq_result_t step_result;
    logic        out_valid_reg;
    logic        advance;
    logic        fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = advance && in_valid_reg;
    assign s_tready = !in_valid_reg || advance;

    i2crts_step u_step (
        .state_cur  (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.kind             <= s_tuser;
            in_item_reg.direction        <= s_tdata[0];
            in_item_reg.device_address   <= s_tdata[7:1];
            in_item_reg.register_address <= s_tdata[15:8];
            in_item_reg.length           <= s_tdata[23:16];
            in_item_reg.write_byte       <= s_tdata[31:24];
            in_item_reg.bus_status       <= s_tdata[39:32];
            in_item_reg.received_byte    <= s_tdata[47:40];
        end
        if (fire)
        begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_result_reg.failed,
                       out_result_reg.done_res,
                       out_result_reg.read_index,
                       out_result_reg.read_data,
                       out_result_reg.read_valid,
                       out_result_reg.want_write_byte,
                       out_result_reg.command_byte,
                       out_result_reg.command};

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && step_result.done_res |=> state_reg.phase == PH_IDLE)
        else $error("Sequencer did not return to idle after a finished transfer.");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && step_result.want_write_byte |=> state_reg.phase == PH_NEED)
        else $error("Data byte requested but sequencer is not waiting for one.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.failed |-> out_result_reg.done_res)
        else $error("Failure flagged on a result that does not end the transfer.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.read_valid |->
            (out_result_reg.command == CMD_RACK || out_result_reg.command == CMD_RNACK
             || out_result_reg.command == CMD_STOP))
        else $error("Received byte delivered with an unexpected bus command.");

endmodule
